FILE: rtl/core/pbba_pkg.sv
`timescale 1ns / 1ps

package pbba_pkg;

    localparam int HEAP_BYTES  = 65536;
    localparam int NUM_BUCKETS = 14;
    localparam int CHUNK_SHIFT = 11;
    localparam int NBLK        = HEAP_BYTES / 8;
    localparam int IDX_W       = $clog2(NBLK);
    localparam int ADDR_W      = 17;
    localparam int BKT_W       = 4;
    localparam int CNT_W       = 14;
    localparam int TAG_W       = 5;
    localparam int LINK_W      = ADDR_W + 1;
    localparam int RUN_W       = CHUNK_SHIFT - 3;
    localparam int PAGE_BITS   = 10;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_OOM      = 3'd1;
    localparam logic [2:0] STAT_NULL     = 3'd2;
    localparam logic [2:0] STAT_EARLY    = 3'd3;
    localparam logic [2:0] STAT_ABOVE    = 3'd4;
    localparam logic [2:0] STAT_BELOW    = 3'd5;
    localparam logic [2:0] STAT_NOTALLOC = 3'd6;
    localparam logic [2:0] STAT_BADIDX   = 3'd7;

    typedef struct packed {
        logic        operation;
        logic [16:0] request_bytes;
        logic [16:0] user_address;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] granted_address;
        logic [3:0]  bucket_used;
        logic [13:0] bucket_in_use;
    } rsp_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ASIZE,
        S_RPAD,
        S_RCHK,
        S_CHAIN,
        S_APOP,
        S_AGRANT,
        S_FCHK,
        S_FTAG
    } state_t;

    // Index of the highest set bit; the argument is never zero here.
    function automatic logic [BKT_W-1:0] msb_index(input logic [15:0] v);
        logic [BKT_W-1:0] r;
        r = '0;
        for (int i = 0; i < 16; i++) begin
            if (v[i]) begin
                r = BKT_W'(i);
            end
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/pbba_ram.sv
`timescale 1ns / 1ps

module pbba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/power_of_two_bucket_allocator_top.sv
`timescale 1ns / 1ps

// Channel    Direction  Handshake             Payload
// request    in         start high, busy low  pbba_pkg::req_t
// result     out        done strobe, 1 cycle  pbba_pkg::rsp_t
//
// After reset the block tag memory is swept to "not allocated", one entry per cycle,
// which keeps busy high until the whole memory has been swept.
// An allocate whose bucket list holds a block passes through the size, pop and grant states
// before its result; an oversized allocate is answered from the size state.
// A refill passes through the pad and check states, then chains up to 256 blocks for the
// smallest bucket through the single chaining adder and the link memory write port.
// A refill that does not fit is answered out of memory from the check state.
// A free passes the address and tag checks, or stops at the address checks if they reject it.
// The receiver cannot stall: each result is shown for one cycle.

module power_of_two_bucket_allocator_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  pbba_pkg::req_t  request,
    output logic            done,
    output pbba_pkg::rsp_t  result
);

    pbba_pkg::state_t state_reg, state_next;
    pbba_pkg::req_t   req_reg, req_next;
    logic [pbba_pkg::BKT_W-1:0] bucket_reg, bucket_next;
    logic             oversize_reg, oversize_next;

    // Per-bucket list heads and counts live in flops; they are read at one index.
    logic [pbba_pkg::ADDR_W-1:0] list_head_reg [pbba_pkg::NUM_BUCKETS];
    logic [pbba_pkg::ADDR_W-1:0] list_head_next [pbba_pkg::NUM_BUCKETS];
    logic                        head_valid_reg [pbba_pkg::NUM_BUCKETS];
    logic                        head_valid_next [pbba_pkg::NUM_BUCKETS];
    logic [pbba_pkg::CNT_W-1:0]  in_use_reg [pbba_pkg::NUM_BUCKETS];
    logic [pbba_pkg::CNT_W-1:0]  in_use_next [pbba_pkg::NUM_BUCKETS];

    logic [pbba_pkg::ADDR_W-1:0] heap_top_reg, heap_top_next;
    logic [pbba_pkg::ADDR_W-1:0] mem_bottom_reg, mem_bottom_next;
    logic [pbba_pkg::ADDR_W-1:0] mem_top_reg, mem_top_next;
    logic                        started_reg, started_next;
    logic [pbba_pkg::ADDR_W-1:0] pos_reg, pos_next;
    logic [pbba_pkg::RUN_W-1:0]  run_reg, run_next;
    logic [pbba_pkg::IDX_W-1:0]  clr_reg, clr_next;
    logic                        done_reg, done_next;
    pbba_pkg::rsp_t              result_reg, result_next;

    // Memory ports.
    logic                        link_we;
    logic [pbba_pkg::IDX_W-1:0]  link_waddr, link_raddr;
    logic [pbba_pkg::LINK_W-1:0] link_wdata, link_rdata;
    logic                        tag_we;
    logic [pbba_pkg::IDX_W-1:0]  tag_waddr, tag_raddr;
    logic [pbba_pkg::TAG_W-1:0]  tag_wdata, tag_rdata;

    // Derived values.
    logic [pbba_pkg::BKT_W-1:0]  sel_bkt;
    logic [pbba_pkg::TAG_W-1:0]  tag_minus;
    logic [pbba_pkg::ADDR_W-1:0] cur_head;
    logic                        cur_valid;
    logic [pbba_pkg::CNT_W-1:0]  cur_count;
    logic [17:0]                 nbytes;
    logic [17:0]                 nbytes_m1;
    logic [4:0]                  blk_shift;
    logic [4:0]                  chunk_shift;
    logic [17:0]                 chunk;
    logic                        fits;
    logic [pbba_pkg::ADDR_W-1:0] blk_size;
    logic [pbba_pkg::ADDR_W-1:0] chain_sum;
    logic [17:0]                 padded;
    logic [pbba_pkg::ADDR_W-1:0] free_pos;
    logic                        free_err;
    logic [2:0]                  free_stat;
    logic [pbba_pkg::RUN_W-1:0]  run_init;
    logic [4:0]                  run_shamt;

    pbba_ram #(
        .WIDTH(pbba_pkg::LINK_W),
        .DEPTH(pbba_pkg::NBLK)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    pbba_ram #(
        .WIDTH(pbba_pkg::TAG_W),
        .DEPTH(pbba_pkg::NBLK)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .raddr (tag_raddr),
        .rdata (tag_rdata)
    );

    // During the tag check of a free, the bucket comes from the tag just read.
    assign tag_minus = tag_rdata - pbba_pkg::TAG_W'(1);
    assign sel_bkt   = (state_reg == pbba_pkg::S_FTAG) ? tag_minus[pbba_pkg::BKT_W-1:0]
                                                       : bucket_reg;
    assign cur_head  = list_head_reg[sel_bkt];
    assign cur_valid = head_valid_reg[sel_bkt];
    assign cur_count = in_use_reg[sel_bkt];

    // Request size with header, rounded to eight bytes.
    assign nbytes    = ({1'b0, request.request_bytes} + 18'd15) & ~18'd7;
    assign nbytes_m1 = nbytes - 18'd1;

    // Refill geometry for the current bucket.
    assign blk_shift   = 5'(bucket_reg) + 5'd3;
    assign chunk_shift = (blk_shift <= 5'(pbba_pkg::CHUNK_SHIFT)) ? 5'(pbba_pkg::CHUNK_SHIFT)
                                                                 : blk_shift;
    assign chunk       = 18'd1 << chunk_shift;
    assign fits        = ({1'b0, heap_top_reg} + chunk) <= 18'(pbba_pkg::HEAP_BYTES);
    assign blk_size    = pbba_pkg::ADDR_W'(1) << blk_shift;
    assign chain_sum   = pos_reg + blk_size;
    assign run_shamt   = 5'(pbba_pkg::CHUNK_SHIFT) - blk_shift;
    assign run_init    = (blk_shift >= 5'(pbba_pkg::CHUNK_SHIFT)) ? '0 :
                         pbba_pkg::RUN_W'(((pbba_pkg::RUN_W+1)'(1) << run_shamt)
                                          - (pbba_pkg::RUN_W+1)'(1));

    // Heap top padded up to the next 1 KiB boundary, saturated at the heap end.
    always_comb
    begin
        padded = {1'b0, heap_top_reg[pbba_pkg::ADDR_W-1:pbba_pkg::PAGE_BITS], 10'd0}
                 + 18'd1024;
        if (padded > 18'(pbba_pkg::HEAP_BYTES))
        begin
            padded = 18'(pbba_pkg::HEAP_BYTES);
        end
    end

    // Address checks of a free, in priority order.
    assign free_pos = req_reg.user_address - pbba_pkg::ADDR_W'(8);

    always_comb
    begin
        free_err  = 1'b1;
        free_stat = pbba_pkg::STAT_NOTALLOC;
        if (req_reg.user_address == '0)
        begin
            free_stat = pbba_pkg::STAT_NULL;
        end
        else if (!started_reg)
        begin
            free_stat = pbba_pkg::STAT_EARLY;
        end
        else if (req_reg.user_address > mem_top_reg)
        begin
            free_stat = pbba_pkg::STAT_ABOVE;
        end
        else if (req_reg.user_address < mem_bottom_reg)
        begin
            free_stat = pbba_pkg::STAT_BELOW;
        end
        else if (req_reg.user_address < pbba_pkg::ADDR_W'(8)
                 || req_reg.user_address[2:0] != 3'd0)
        begin
            free_stat = pbba_pkg::STAT_NOTALLOC;
        end
        else
        begin
            free_err = 1'b0;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pbba_pkg::S_CLEAR:
            begin
                if (clr_reg == pbba_pkg::IDX_W'(pbba_pkg::NBLK - 1))
                begin
                    state_next = pbba_pkg::S_IDLE;
                end
            end
            pbba_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = (request.operation == pbba_pkg::OP_FREE) ? pbba_pkg::S_FCHK
                                                                          : pbba_pkg::S_ASIZE;
                end
            end
            pbba_pkg::S_ASIZE:
            begin
                if (oversize_reg)
                begin
                    state_next = pbba_pkg::S_IDLE;
                end
                else if (cur_valid)
                begin
                    state_next = pbba_pkg::S_APOP;
                end
                else
                begin
                    state_next = pbba_pkg::S_RPAD;
                end
            end
            pbba_pkg::S_RPAD:   state_next = pbba_pkg::S_RCHK;
            pbba_pkg::S_RCHK:   state_next = fits ? pbba_pkg::S_CHAIN : pbba_pkg::S_IDLE;
            pbba_pkg::S_CHAIN:
            begin
                if (run_reg == '0)
                begin
                    state_next = pbba_pkg::S_APOP;
                end
            end
            pbba_pkg::S_APOP:   state_next = pbba_pkg::S_AGRANT;
            pbba_pkg::S_AGRANT: state_next = pbba_pkg::S_IDLE;
            pbba_pkg::S_FCHK:   state_next = free_err ? pbba_pkg::S_IDLE : pbba_pkg::S_FTAG;
            pbba_pkg::S_FTAG:   state_next = pbba_pkg::S_IDLE;
            default:            state_next = pbba_pkg::S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        req_next        = req_reg;
        bucket_next     = bucket_reg;
        oversize_next   = oversize_reg;
        list_head_next  = list_head_reg;
        head_valid_next = head_valid_reg;
        in_use_next     = in_use_reg;
        heap_top_next   = heap_top_reg;
        mem_bottom_next = mem_bottom_reg;
        mem_top_next    = mem_top_reg;
        started_next    = started_reg;
        pos_next        = pos_reg;
        run_next        = run_reg;
        clr_next        = clr_reg;
        done_next       = 1'b0;
        result_next     = '0;
        link_we         = 1'b0;
        link_waddr      = pos_reg[15:3];
        link_wdata      = '0;
        link_raddr      = cur_head[15:3];
        tag_we          = 1'b0;
        tag_waddr       = free_pos[15:3];
        tag_wdata       = '0;
        tag_raddr       = free_pos[15:3];

        case (state_reg)
            pbba_pkg::S_CLEAR:
            begin
                tag_we    = 1'b1;
                tag_waddr = clr_reg;
                clr_next  = clr_reg + pbba_pkg::IDX_W'(1);
            end
            pbba_pkg::S_IDLE:
            begin
                if (start)
                begin
                    req_next      = request;
                    bucket_next   = pbba_pkg::msb_index(nbytes_m1[17:2]);
                    oversize_next = 5'(pbba_pkg::msb_index(nbytes_m1[17:2]))
                                    >= 5'(pbba_pkg::NUM_BUCKETS);
                end
            end
            pbba_pkg::S_ASIZE:
            begin
                if (oversize_reg)
                begin
                    done_next          = 1'b1;
                    result_next.status = pbba_pkg::STAT_OOM;
                end
            end
            pbba_pkg::S_RPAD:
            begin
                mem_top_next = heap_top_reg;
                if (!started_reg)
                begin
                    mem_bottom_next = heap_top_reg;
                    started_next    = 1'b1;
                end
                if (heap_top_reg[pbba_pkg::PAGE_BITS-1:0] != '0)
                begin
                    heap_top_next = padded[pbba_pkg::ADDR_W-1:0];
                    mem_top_next  = padded[pbba_pkg::ADDR_W-1:0];
                end
            end
            pbba_pkg::S_RCHK:
            begin
                if (fits)
                begin
                    pos_next                    = heap_top_reg;
                    heap_top_next               = heap_top_reg + chunk[pbba_pkg::ADDR_W-1:0];
                    mem_top_next                = heap_top_reg + chunk[pbba_pkg::ADDR_W-1:0];
                    list_head_next[bucket_reg]  = heap_top_reg;
                    head_valid_next[bucket_reg] = 1'b1;
                    run_next                    = run_init;
                end
                else
                begin
                    done_next                 = 1'b1;
                    result_next.status        = pbba_pkg::STAT_OOM;
                    result_next.bucket_used   = bucket_reg;
                    result_next.bucket_in_use = cur_count;
                end
            end
            pbba_pkg::S_CHAIN:
            begin
                // One link per cycle through the chaining adder; the last block ends the list.
                link_we = 1'b1;
                if (run_reg != '0)
                begin
                    link_wdata = {1'b1, chain_sum};
                    pos_next   = chain_sum;
                    run_next   = run_reg - pbba_pkg::RUN_W'(1);
                end
            end
            pbba_pkg::S_APOP:
            begin
                link_raddr = cur_head[15:3];
            end
            pbba_pkg::S_AGRANT:
            begin
                list_head_next[bucket_reg]  = link_rdata[pbba_pkg::ADDR_W-1:0];
                head_valid_next[bucket_reg] = link_rdata[pbba_pkg::LINK_W-1];
                in_use_next[bucket_reg]     = cur_count + pbba_pkg::CNT_W'(1);
                tag_we                      = 1'b1;
                tag_waddr                   = cur_head[15:3];
                tag_wdata                   = pbba_pkg::TAG_W'(bucket_reg) + pbba_pkg::TAG_W'(1);
                done_next                   = 1'b1;
                result_next.status          = pbba_pkg::STAT_OK;
                result_next.granted_address = 16'(cur_head + pbba_pkg::ADDR_W'(8));
                result_next.bucket_used     = bucket_reg;
                result_next.bucket_in_use   = cur_count + pbba_pkg::CNT_W'(1);
            end
            pbba_pkg::S_FCHK:
            begin
                if (free_err)
                begin
                    done_next          = 1'b1;
                    result_next.status = free_stat;
                end
            end
            pbba_pkg::S_FTAG:
            begin
                done_next = 1'b1;
                if (tag_rdata == '0)
                begin
                    result_next.status = pbba_pkg::STAT_NOTALLOC;
                end
                else if (tag_rdata > pbba_pkg::TAG_W'(pbba_pkg::NUM_BUCKETS))
                begin
                    result_next.status = pbba_pkg::STAT_BADIDX;
                end
                else
                begin
                    tag_we                    = 1'b1;
                    tag_wdata                 = '0;
                    link_we                   = 1'b1;
                    link_waddr                = free_pos[15:3];
                    link_wdata                = {cur_valid, cur_head};
                    list_head_next[sel_bkt]   = free_pos;
                    head_valid_next[sel_bkt]  = 1'b1;
                    in_use_next[sel_bkt]      = cur_count - pbba_pkg::CNT_W'(1);
                    result_next.status        = pbba_pkg::STAT_OK;
                    result_next.bucket_used   = sel_bkt;
                    result_next.bucket_in_use = cur_count - pbba_pkg::CNT_W'(1);
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pbba_pkg::S_CLEAR;
            heap_top_reg   <= '0;
            mem_bottom_reg <= '0;
            mem_top_reg    <= '0;
            started_reg    <= 1'b0;
            clr_reg        <= '0;
            done_reg       <= 1'b0;
            for (int i = 0; i < pbba_pkg::NUM_BUCKETS; i++)
            begin
                head_valid_reg[i] <= 1'b0;
                in_use_reg[i]     <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            heap_top_reg   <= heap_top_next;
            mem_bottom_reg <= mem_bottom_next;
            mem_top_reg    <= mem_top_next;
            started_reg    <= started_next;
            clr_reg        <= clr_next;
            done_reg       <= done_next;
            head_valid_reg <= head_valid_next;
            in_use_reg     <= in_use_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        bucket_reg    <= bucket_next;
        oversize_reg  <= oversize_next;
        list_head_reg <= list_head_next;
        pos_reg       <= pos_next;
        run_reg       <= run_next;
        result_reg    <= result_next;
    end

    assign busy   = (state_reg != pbba_pkg::S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // A transfer always starts work, so busy rises right after it.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after a transfer");

    // Every result closes a busy period.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without work in progress");

    // Two results never come back to back.
    a_done_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("results in consecutive cycles");

    // A failed free touches no bucket.
    a_free_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != pbba_pkg::STAT_OK && result.status != pbba_pkg::STAT_OOM)
        |-> (result.bucket_used == '0 && result.bucket_in_use == '0))
        else $error("failed free reports a bucket");

    // Only a successful allocate grants an address.
    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != pbba_pkg::STAT_OK) |-> (result.granted_address == '0))
        else $error("address granted on failure");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int CLEAR_CYCLES = 8192;
    localparam int MAX_CYCLES   = 1500000;
    localparam int N_RANDOM     = 1000;
    localparam int PAD_CYCLES   = 300;

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    pbba_pkg::req_t request;
    logic           done;
    pbba_pkg::rsp_t result;

    // Predictor copy of the allocator state.
    logic [16:0] head_addr [pbba_pkg::NUM_BUCKETS];
    bit          head_ok   [pbba_pkg::NUM_BUCKETS];
    logic [16:0] link_addr [pbba_pkg::NBLK];
    bit          link_ok   [pbba_pkg::NBLK];
    logic [4:0]  tag_mem   [pbba_pkg::NBLK];
    logic [13:0] live_cnt  [pbba_pkg::NUM_BUCKETS];
    int unsigned top_ptr;
    int unsigned low_mark;
    int unsigned high_mark;
    bit          started;

    // Addresses handed out and not yet freed, used to build legal frees.
    logic [16:0]    live_addrs[$];
    pbba_pkg::rsp_t pending_results[$];

    int unsigned cycle_count;
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned allocs_ok;
    int unsigned frees_ok;
    int unsigned oom_seen;
    int unsigned errs_seen;

    // Directed table: each row is a request and optionally a typed-in answer.
    typedef struct {
        pbba_pkg::req_t req;
        bit             has_exp;
        pbba_pkg::rsp_t exp;
    } row_t;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    power_of_two_bucket_allocator_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    function automatic void reset_model();
        for (int b = 0; b < pbba_pkg::NUM_BUCKETS; b++)
        begin
            head_addr[b] = '0;
            head_ok[b]   = 1'b0;
            live_cnt[b]  = '0;
        end
        for (int i = 0; i < pbba_pkg::NBLK; i++)
        begin
            link_addr[i] = '0;
            link_ok[i]   = 1'b0;
            tag_mem[i]   = '0;
        end
        top_ptr   = 0;
        low_mark  = 0;
        high_mark = 0;
        started   = 1'b0;
    endfunction

    // Carve a fresh chunk from the heap top into bucket b's empty free list.
    function automatic void refill_bucket(int unsigned b);
        int unsigned shift_amt;
        int unsigned chunk;
        int unsigned pos;
        int unsigned siz;
        int unsigned nblks;
        high_mark = top_ptr;
        if (!started)
        begin
            low_mark = high_mark;
            started  = 1'b1;
        end
        if (top_ptr % 1024 != 0)
        begin
            top_ptr = top_ptr + 1024 - (top_ptr % 1024);
            if (top_ptr > pbba_pkg::HEAP_BYTES)
            begin
                top_ptr = pbba_pkg::HEAP_BYTES;
            end
            high_mark = top_ptr;
        end
        shift_amt = (b + 3 <= pbba_pkg::CHUNK_SHIFT) ? pbba_pkg::CHUNK_SHIFT : b + 3;
        chunk = 1 << shift_amt;
        if (top_ptr + chunk > pbba_pkg::HEAP_BYTES)
        begin
            return;
        end
        pos = top_ptr;
        top_ptr += chunk;
        high_mark = top_ptr;
        siz = 1 << (b + 3);
        nblks = chunk >> (b + 3);
        head_addr[b] = 17'(pos);
        head_ok[b] = 1'b1;
        for (int i = 1; i < nblks; i++)
        begin
            link_addr[(pos >> 3) % pbba_pkg::NBLK] = 17'(pos + siz);
            link_ok[(pos >> 3) % pbba_pkg::NBLK]   = 1'b1;
            pos += siz;
        end
        link_ok[(pos >> 3) % pbba_pkg::NBLK]   = 1'b0;
        link_addr[(pos >> 3) % pbba_pkg::NBLK] = '0;
    endfunction

    function automatic pbba_pkg::rsp_t predict_allocation(pbba_pkg::req_t rq);
        pbba_pkg::rsp_t r;
        int unsigned nbytes;
        int unsigned sh;
        int unsigned b;
        int unsigned pos;
        int unsigned idx;
        r = '0;
        if (rq.operation == pbba_pkg::OP_ALLOC)
        begin
            nbytes = (8 + rq.request_bytes + 7) & ~32'd7;
            sh = (nbytes - 1) >> 2;
            b = 0;
            sh = sh >> 1;
            while (sh != 0)
            begin
                b++;
                sh = sh >> 1;
            end
            if (b >= pbba_pkg::NUM_BUCKETS)
            begin
                r.status = pbba_pkg::STAT_OOM;
                return r;
            end
            if (!head_ok[b])
            begin
                refill_bucket(b);
            end
            if (!head_ok[b])
            begin
                r.status = pbba_pkg::STAT_OOM;
                r.bucket_used = 4'(b);
                r.bucket_in_use = live_cnt[b];
                return r;
            end
            pos = head_addr[b];
            idx = (pos >> 3) % pbba_pkg::NBLK;
            head_addr[b] = link_addr[idx];
            head_ok[b] = link_ok[idx];
            tag_mem[idx] = 5'(b + 1);
            live_cnt[b] = live_cnt[b] + 14'd1;
            r.status = pbba_pkg::STAT_OK;
            r.granted_address = 16'(pos + 8);
            r.bucket_used = 4'(b);
            r.bucket_in_use = live_cnt[b];
            live_addrs.push_back(17'(pos + 8));
        end
        else
        begin
            if (rq.user_address == 0)
            begin
                r.status = pbba_pkg::STAT_NULL;
            end
            else if (!started)
            begin
                r.status = pbba_pkg::STAT_EARLY;
            end
            else if (rq.user_address > high_mark)
            begin
                r.status = pbba_pkg::STAT_ABOVE;
            end
            else if (rq.user_address < low_mark)
            begin
                r.status = pbba_pkg::STAT_BELOW;
            end
            else if (rq.user_address < 8 || rq.user_address[2:0] != 3'd0)
            begin
                r.status = pbba_pkg::STAT_NOTALLOC;
            end
            else
            begin
                pos = rq.user_address - 8;
                idx = pos >> 3;
                if (idx >= pbba_pkg::NBLK || tag_mem[idx] == 0)
                begin
                    r.status = pbba_pkg::STAT_NOTALLOC;
                end
                else if (tag_mem[idx] - 1 >= pbba_pkg::NUM_BUCKETS)
                begin
                    r.status = pbba_pkg::STAT_BADIDX;
                end
                else
                begin
                    b = tag_mem[idx] - 1;
                    tag_mem[idx] = '0;
                    link_addr[idx] = head_addr[b];
                    link_ok[idx] = head_ok[b];
                    head_addr[b] = 17'(pos);
                    head_ok[b] = 1'b1;
                    live_cnt[b] = live_cnt[b] - 14'd1;
                    r.status = pbba_pkg::STAT_OK;
                    r.bucket_used = 4'(b);
                    r.bucket_in_use = live_cnt[b];
                    foreach (live_addrs[k])
                    begin
                        if (live_addrs[k] == rq.user_address)
                        begin
                            live_addrs.delete(k);
                            break;
                        end
                    end
                end
            end
        end
        return r;
    endfunction

    // Half the time no gap between transfers, else mostly a short one, now and then a long one.
    task automatic idle_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            return;
        end
        else if (pick < 95)
        begin
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        else
        begin
            repeat ($urandom_range(10, 40)) @(negedge clk);
        end
    endtask

    // Present one request at the falling edge and hold it until a rising edge
    // sees start high with busy low. The expected result is queued at that transfer;
    // a typed-in answer takes the place of the predicted one.
    task automatic send_request(pbba_pkg::req_t rq, bit has_exp, pbba_pkg::rsp_t exp);
        pbba_pkg::rsp_t p;
        request = rq;
        start   = 1'b1;
        forever
        begin
            @(posedge clk);
            if (!busy)
            begin
                break;
            end
        end
        p = predict_allocation(rq);
        if (has_exp && p != exp)
        begin
            $display("table row disagrees with predictor: %h vs %h", exp, p);
        end
        pending_results.push_back(has_exp ? exp : p);
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Random request: mostly allocs, some of them oversized, and frees of live blocks; the rest
    // malformed or stray frees.
    function automatic pbba_pkg::req_t random_request();
        pbba_pkg::req_t rq;
        int unsigned pick;
        rq = '0;
        rq.request_bytes = 17'($urandom);
        rq.user_address  = 17'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            rq.operation = pbba_pkg::OP_ALLOC;
            case ($urandom_range(0, 3))
                0: rq.request_bytes = 17'($urandom_range(0, 64));
                1: rq.request_bytes = 17'($urandom_range(0, 1024));
                2: rq.request_bytes = 17'($urandom_range(0, 8192));
                default: rq.request_bytes = 17'($urandom_range(0, 65536));
            endcase
        end
        else if (pick < 85 && live_addrs.size() != 0)
        begin
            rq.operation = pbba_pkg::OP_FREE;
            rq.user_address = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
        end
        else
        begin
            rq.operation = pbba_pkg::OP_FREE;
            case ($urandom_range(0, 3))
                0: rq.user_address = 17'($urandom_range(0, 65536));
                1: rq.user_address = '0;
                2: rq.user_address = 17'($urandom_range(1, 8191) * 8);
                default: rq.user_address = 17'($urandom_range(65536, 131071));
            endcase
        end
        return rq;
    endfunction

    // Results cannot be held off, so the checker simply samples every strobe.
    always @(posedge clk)
    begin
        pbba_pkg::rsp_t exp;
        if (rst_n && done)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result %h", result);
                end
            end
            else
            begin
                exp = pending_results.pop_front();
                if (result !== exp)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: status %0d/%0d addr %h/%h bucket %0d/%0d",
                            exp.status, result.status, exp.granted_address,
                            result.granted_address, exp.bucket_used, result.bucket_used);
                        $display("          count %0d/%0d",
                            exp.bucket_in_use, result.bucket_in_use);
                    end
                end
                else if (exp.status == pbba_pkg::STAT_OK)
                begin
                    if (exp.granted_address != 0)
                    begin
                        allocs_ok++;
                    end
                    else
                    begin
                        frees_ok++;
                    end
                end
                else if (exp.status == pbba_pkg::STAT_OOM)
                begin
                    oom_seen++;
                end
                else
                begin
                    errs_seen++;
                end
            end
        end
    end

    // Watchdog: the clear sweep, refill chains and gaps all fit well inside this.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("FAIL power_of_two_bucket_allocator_top");
            $finish;
        end
    end

    initial
    begin
        row_t rows[$];
        row_t rw;
        pbba_pkg::req_t rq;
        pbba_pkg::rsp_t none;

        cycle_count = 0;
        mismatches = 0;
        results_seen = 0;
        allocs_ok = 0;
        frees_ok = 0;
        oom_seen = 0;
        errs_seen = 0;
        none = '0;
        start = 1'b0;
        request = '0;
        rst_n = 1'b0;
        reset_model();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed rows: early and null frees, smallest and largest requests,
        // oversized asks, frees of bad addresses, then heap exhaustion.
        rw.has_exp = 1'b1;
        rw.req = '{pbba_pkg::OP_FREE, 17'd0, 17'd0};
        rw.exp = '{pbba_pkg::STAT_NULL, 16'd0, 4'd0, 14'd0};
        rows.push_back(rw);
        rw.req = '{pbba_pkg::OP_FREE, 17'd0, 17'd8};
        rw.exp = '{pbba_pkg::STAT_EARLY, 16'd0, 4'd0, 14'd0};
        rows.push_back(rw);
        rw.req = '{pbba_pkg::OP_ALLOC, 17'd0, 17'h1ffff};
        rw.exp = '{pbba_pkg::STAT_OK, 16'd8, 4'd0, 14'd1};
        rows.push_back(rw);
        rw.req = '{pbba_pkg::OP_ALLOC, 17'd65536, 17'd0};
        rw.exp = '{pbba_pkg::STAT_OOM, 16'd0, 4'd0, 14'd0};
        rows.push_back(rw);
        rw.req = '{pbba_pkg::OP_ALLOC, 17'h1ffff, 17'd0};
        rw.exp = '{pbba_pkg::STAT_OOM, 16'd0, 4'd0, 14'd0};
        rows.push_back(rw);
        rw.has_exp = 1'b0;
        rw.exp = none;
        rw.req = '{pbba_pkg::OP_ALLOC, 17'd8, 17'd0};
        rows.push_back(rw);
        rw.req = '{pbba_pkg::OP_ALLOC, 17'd100, 17'd0};
        rows.push_back(rw);
        rw.req = '{pbba_pkg::OP_ALLOC, 17'd65528, 17'd0};
        rows.push_back(rw);
        rw.req = '{pbba_pkg::OP_FREE, 17'h1ffff, 17'd8};
        rows.push_back(rw);
        rw.req = '{pbba_pkg::OP_FREE, 17'd0, 17'd8};
        rows.push_back(rw);
        rw.req = '{pbba_pkg::OP_FREE, 17'd0, 17'd12};
        rows.push_back(rw);
        rw.req = '{pbba_pkg::OP_FREE, 17'd0, 17'd4};
        rows.push_back(rw);
        rw.req = '{pbba_pkg::OP_FREE, 17'd0, 17'h1ffff};
        rows.push_back(rw);
        rw.req = '{pbba_pkg::OP_FREE, 17'd0, 17'd2056};
        rows.push_back(rw);
        rw.req = '{pbba_pkg::OP_ALLOC, 17'd32760, 17'd0};
        rows.push_back(rw);
        rw.req = '{pbba_pkg::OP_ALLOC, 17'd16376, 17'd0};
        rows.push_back(rw);
        rw.req = '{pbba_pkg::OP_ALLOC, 17'd8184, 17'd0};
        rows.push_back(rw);
        rw.req = '{pbba_pkg::OP_ALLOC, 17'd4088, 17'd0};
        rows.push_back(rw);
        rw.req = '{pbba_pkg::OP_ALLOC, 17'd2040, 17'd0};
        rows.push_back(rw);
        rw.req = '{pbba_pkg::OP_ALLOC, 17'd32760, 17'd0};
        rows.push_back(rw);
        rw.req = '{pbba_pkg::OP_ALLOC, 17'd1000, 17'd0};
        rows.push_back(rw);

        foreach (rows[i])
        begin
            send_request(rows[i].req, rows[i].has_exp, rows[i].exp);
            idle_gap();
        end
        // Free everything the table handed out, then let the block drain fully.
        while (live_addrs.size() != 0)
        begin
            rq = '{pbba_pkg::OP_FREE, 17'($urandom), live_addrs[0]};
            send_request(rq, 1'b0, none);
        end
        wait_drained();

        for (int n = 0; n < N_RANDOM; n++)
        begin
            send_request(random_request(), 1'b0, none);
            if (n % 200 < 150)
            begin
                idle_gap();
            end
            if (n == N_RANDOM / 2)
            begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (PAD_CYCLES) @(negedge clk);
        $display("Run covered %0d results: %0d allocations, %0d frees, %0d out of memory,",
            results_seen, allocs_ok, frees_ok, oom_seen);
        $display("and %0d rejected frees, including heap exhaustion and a full drain.",
            errs_seen);
        if (mismatches == 0)
        begin
            $display("PASS power_of_two_bucket_allocator_top");
        end
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("FAIL power_of_two_bucket_allocator_top");
        end
        $finish;
    end

endmodule
